// ----- rtl/core/gql_pkg.sv -----
// gql_pkg: shared types and constants for the glyph quad layout block.
// No dependencies; all rtl/core files but gql_table use it by scoped names.
package gql_pkg;

  // item opcodes carried on the input channel
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_PLACE = 2'd1,
    ACT_BEGIN = 2'd2,
    ACT_RSVD  = 2'd3
  } act_t;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCREEN_SPACE = 2'd0,
    CFG_LINE_HEIGHT  = 2'd1
  } cfg_reg_t;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // glyph entry slots, u in the lowest slot
  localparam int G_U      = 0;
  localparam int G_V      = 1;
  localparam int G_W      = 2;
  localparam int G_H      = 3;
  localparam int G_XO     = 4;
  localparam int G_YO     = 5;
  localparam int G_ADV    = 6;
  localparam int G_FIELDS = 7;

  // vertex numbering inside the quad
  localparam int         CORNER_W     = 3;
  localparam logic [2:0] CORNER_FIRST = 3'd0;
  localparam logic [2:0] CORNER_LAST  = 3'd5;
  // per corner: takes right edge / u1, takes top edge / vt
  localparam logic [5:0] RIGHT_MASK   = 6'b010110;
  localparam logic [5:0] TOP_MASK     = 6'b110100;

  // decoded item control carried from the accept stage to the pen stage
  typedef struct packed {
    act_t action;
    logic newline;
    logic in_range;
  } item_ctrl_t;

endpackage

// ----- rtl/core/gql_if.sv -----
// gql_if: valid/ready channel interfaces for input items, vertices and
// configuration writes. Depends on gql_pkg.
interface gql_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         char_code;
  logic signed [31:0] glyph_u;
  logic signed [31:0] glyph_v;
  logic [30:0]        glyph_width;
  logic [30:0]        glyph_height;
  logic signed [31:0] glyph_x_offset;
  logic signed [31:0] glyph_y_offset;
  logic [30:0]        glyph_advance;

  modport source (output valid, action, char_code, glyph_u, glyph_v, glyph_width,
                  glyph_height, glyph_x_offset, glyph_y_offset, glyph_advance,
                  input ready);
  modport sink (input valid, action, char_code, glyph_u, glyph_v, glyph_width,
                glyph_height, glyph_x_offset, glyph_y_offset, glyph_advance,
                output ready);
endinterface

interface gql_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic [2:0]         corner;
  logic               last;

  modport source (output valid, vertex_x, vertex_y, tex_u, tex_v, corner, last,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, tex_u, tex_v, corner, last,
                output ready);
endinterface

interface gql_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gql_pkg::CFG_ADDR_W-1:0]  addr;
  logic [31:0]                     data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/gql_table.sv -----
// gql_table: glyph table, one synchronous RAM, registered read port.
// Depends on nothing outside its parameters.
module gql_table #(
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(GLYPH_COUNT)-1:0] waddr,
  input  logic [7*COORD_BITS-1:0]        wdata,
  input  logic                           re,
  input  logic [$clog2(GLYPH_COUNT)-1:0] raddr,
  output logic [7*COORD_BITS-1:0]        rdata_r
);

  logic [7*COORD_BITS-1:0] mem [GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/gql_pen.sv -----
// gql_pen: pen stage. Holds one looked-up item, forms quad edges from the pen,
// and updates the pen in item order. Depends on gql_pkg.
module gql_pen #(
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_load,
  input  gql_pkg::item_ctrl_t         ctrl_in,
  input  logic [7*COORD_BITS-1:0]     glyph,
  input  logic                        screen_space,
  input  logic [30:0]                 line_height,
  input  logic                        q_free,
  output logic                        s1_ready,
  output logic                        q_load,
  output logic [COORD_BITS-1:0]       q_left,
  output logic [COORD_BITS-1:0]       q_top,
  output logic [COORD_BITS-1:0]       q_u0,
  output logic [COORD_BITS-1:0]       q_u1,
  output logic [COORD_BITS-1:0]       q_vb,
  output logic [COORD_BITS-1:0]       q_vt,
  output logic [COORD_BITS-1:0]       q_w,
  output logic [COORD_BITS-1:0]       q_h
);

  localparam int CB = COORD_BITS;

  logic                s1_v_r, s1_v_nxt;
  gql_pkg::item_ctrl_t ctrl_r;
  logic [CB-1:0]       pen_x_r, pen_x_nxt;
  logic [CB-1:0]       pen_y_r, pen_y_nxt;
  logic [7*CB-1:0]     g;
  logic [CB-1:0]       g_u, g_v, g_w, g_h, g_xo, g_yo, g_adv, lh;
  logic                is_glyph, s1_adv;

  // out-of-range codes place an all-zero glyph
  assign g     = ctrl_r.in_range ? glyph : '0;
  assign g_u   = g[gql_pkg::G_U*CB   +: CB];
  assign g_v   = g[gql_pkg::G_V*CB   +: CB];
  assign g_w   = g[gql_pkg::G_W*CB   +: CB];
  assign g_h   = g[gql_pkg::G_H*CB   +: CB];
  assign g_xo  = g[gql_pkg::G_XO*CB  +: CB];
  assign g_yo  = g[gql_pkg::G_YO*CB  +: CB];
  assign g_adv = g[gql_pkg::G_ADV*CB +: CB];
  assign lh    = CB'(line_height);

  assign is_glyph = (ctrl_r.action == gql_pkg::ACT_PLACE) && !ctrl_r.newline;
  assign s1_adv   = s1_v_r && (!is_glyph || q_free);
  assign s1_ready = !s1_v_r || s1_adv;
  assign q_load   = s1_v_r && is_glyph && q_free;

  assign q_left = pen_x_r + g_xo;
  assign q_top  = screen_space ? pen_y_r + g_yo : pen_y_r - g_yo;
  assign q_u0   = g_u;
  assign q_u1   = g_u + g_w;
  assign q_vb   = g_v - g_h;
  assign q_vt   = g_v;
  assign q_w    = g_w;
  assign q_h    = g_h;

  always_comb begin
    s1_v_nxt  = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (s1_adv) begin
      case (ctrl_r.action)
        gql_pkg::ACT_PLACE: begin
          if (ctrl_r.newline) begin
            pen_x_nxt = '0;
            pen_y_nxt = screen_space ? pen_y_r + lh : pen_y_r - lh;
          end else begin
            pen_x_nxt = pen_x_r + g_adv;
          end
        end
        gql_pkg::ACT_BEGIN: begin
          pen_x_nxt = '0;
          pen_y_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      ctrl_r <= ctrl_in;
    end
  end

endmodule

// ----- rtl/core/gql_vtx.sv -----
// gql_vtx: quad register and vertex sequencer driving the output register.
// Depends on gql_pkg and gql_out_if.
module gql_vtx #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  screen_space,
  input  logic                  q_load,
  input  logic [COORD_BITS-1:0] q_left,
  input  logic [COORD_BITS-1:0] q_top,
  input  logic [COORD_BITS-1:0] q_u0,
  input  logic [COORD_BITS-1:0] q_u1,
  input  logic [COORD_BITS-1:0] q_vb,
  input  logic [COORD_BITS-1:0] q_vt,
  input  logic [COORD_BITS-1:0] q_w,
  input  logic [COORD_BITS-1:0] q_h,
  output logic                  q_free,
  gql_out_if.source             out_ch
);

  localparam int CB = COORD_BITS;

  logic                            q_v_r, q_v_nxt;
  logic [gql_pkg::CORNER_W-1:0]    cnt_r, cnt_nxt;
  logic [CB-1:0]                   left_r, top_r, u0_r, u1_r, vb_r, vt_r, w_r, h_r;
  logic [CB-1:0]                   right, bottom;
  logic                            out_v_r, out_v_nxt;
  logic                            out_load, last_vtx, is_right, is_top;

  assign right    = left_r + w_r;
  assign bottom   = screen_space ? top_r + h_r : top_r - h_r;
  assign is_right = gql_pkg::RIGHT_MASK[cnt_r];
  assign is_top   = gql_pkg::TOP_MASK[cnt_r];
  assign last_vtx = (cnt_r == gql_pkg::CORNER_LAST);

  assign out_load = q_v_r && (!out_v_r || out_ch.ready);
  assign q_free   = !q_v_r || (out_load && last_vtx);

  always_comb begin
    q_v_nxt   = q_load ? 1'b1 : ((out_load && last_vtx) ? 1'b0 : q_v_r);
    cnt_nxt   = q_load ? gql_pkg::CORNER_FIRST : (out_load ? cnt_r + 3'd1 : cnt_r);
    out_v_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r   <= 1'b0;
      cnt_r   <= gql_pkg::CORNER_FIRST;
      out_v_r <= 1'b0;
    end else begin
      q_v_r   <= q_v_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      left_r <= q_left;
      top_r  <= q_top;
      u0_r   <= q_u0;
      u1_r   <= q_u1;
      vb_r   <= q_vb;
      vt_r   <= q_vt;
      w_r    <= q_w;
      h_r    <= q_h;
    end
    if (out_load) begin
      out_ch.vertex_x <= 32'(is_right ? right : left_r);
      out_ch.vertex_y <= 32'(is_top ? top_r : bottom);
      out_ch.tex_u    <= 32'(is_right ? u1_r : u0_r);
      out_ch.tex_v    <= 32'(is_top ? vt_r : vb_r);
      out_ch.corner   <= cnt_r;
      out_ch.last     <= last_vtx;
    end
  end

  assign out_ch.valid = out_v_r;

endmodule

// ----- rtl/core/glyph_quad_layout_core.sv -----
// glyph_quad_layout_core: top level of the bitmap font quad layout block.
// Depends on gql_pkg, gql_if, gql_table, gql_pen and gql_vtx.
//
//  channel | dir | per transaction
//  --------+-----+----------------------------------------------------------
//  in_ch   | in  | one item: glyph write, character place or begin text
//  out_ch  | out | one vertex: position, texture coordinate, corner, last
//  cfg_ch  | in  | one register write: addr 0 screen_space, 1 line_height
//
//  A placed glyph yields six vertices: the output register moves one vertex
//  per cycle while out_ch.ready allows, and the quad register holds the glyph
//  until its sixth vertex leaves. Glyph writes, begins and newlines bypass
//  the quad register. The table read is registered at the input transaction's
//  edge; the first vertex then moves through the quad and output registers.
//  rst_n is synchronous; it clears pen, pipeline valids and registers, not the
//  glyph table. Output stalls back up through quad, pen stage and in_ch.ready.
module glyph_quad_layout_core #(
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  gql_in_if.sink    in_ch,
  gql_out_if.source out_ch,
  gql_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(GLYPH_COUNT);
  localparam int CB    = COORD_BITS;

  // config regs: the user must write only while the block is idle; unchecked
  logic        ss_r;
  logic [30:0] lh_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_r <= 1'b0;
      lh_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        gql_pkg::CFG_SCREEN_SPACE: ss_r <= cfg_ch.data[0];
        gql_pkg::CFG_LINE_HEIGHT:  lh_r <= cfg_ch.data[30:0];
        default: begin
        end
      endcase
    end
  end

  // accept stage: decode, write or read the glyph table
  logic                in_fire, s1_ready;
  gql_pkg::item_ctrl_t ctrl;
  logic [IDX_W-1:0]    addr;
  logic [7*CB-1:0]     wdata, rdata;
  logic                tbl_we, tbl_re;

  assign in_ch.ready = s1_ready;
  assign in_fire     = in_ch.valid && s1_ready;

  assign ctrl.action   = gql_pkg::act_t'(in_ch.action);
  assign ctrl.newline  = (in_ch.char_code == gql_pkg::NEWLINE_CODE);
  assign ctrl.in_range = ({24'd0, in_ch.char_code} < 32'(GLYPH_COUNT));
  assign addr          = IDX_W'(in_ch.char_code);

  // signed fields sign-extend, size fields zero-extend to the coordinate width
  assign wdata = {CB'(in_ch.glyph_advance),
                  CB'($signed(in_ch.glyph_y_offset)),
                  CB'($signed(in_ch.glyph_x_offset)),
                  CB'(in_ch.glyph_height),
                  CB'(in_ch.glyph_width),
                  CB'($signed(in_ch.glyph_v)),
                  CB'($signed(in_ch.glyph_u))};

  // table ports: a place item reads at its accept edge, so a write accepted
  // earlier is always visible without forwarding
  assign tbl_we = in_fire && (ctrl.action == gql_pkg::ACT_WRITE) && ctrl.in_range;
  assign tbl_re = in_fire && (ctrl.action == gql_pkg::ACT_PLACE) && !ctrl.newline;

  gql_table #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (addr),
    .wdata   (wdata),
    .re      (tbl_re),
    .raddr   (addr),
    .rdata_r (rdata)
  );

  // pen stage to quad register
  logic          q_load, q_free;
  logic [CB-1:0] q_left, q_top, q_u0, q_u1, q_vb, q_vt, q_w, q_h;

  gql_pen #(
    .COORD_BITS (COORD_BITS)
  ) u_pen (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_load      (in_fire),
    .ctrl_in      (ctrl),
    .glyph        (rdata),
    .screen_space (ss_r),
    .line_height  (lh_r),
    .q_free       (q_free),
    .s1_ready     (s1_ready),
    .q_load       (q_load),
    .q_left       (q_left),
    .q_top        (q_top),
    .q_u0         (q_u0),
    .q_u1         (q_u1),
    .q_vb         (q_vb),
    .q_vt         (q_vt),
    .q_w          (q_w),
    .q_h          (q_h)
  );

  // six vertices per quad, one per cycle into the output register when not stalled
  gql_vtx #(
    .COORD_BITS (COORD_BITS)
  ) u_vtx (
    .clk          (clk),
    .rst_n        (rst_n),
    .screen_space (ss_r),
    .q_load       (q_load),
    .q_left       (q_left),
    .q_top        (q_top),
    .q_u0         (q_u0),
    .q_u1         (q_u1),
    .q_vb         (q_vb),
    .q_vt         (q_vt),
    .q_w          (q_w),
    .q_h          (q_h),
    .q_free       (q_free),
    .out_ch       (out_ch)
  );

endmodule

// ----- rtl/core/gql_checker.sv -----
// gql_checker: port-level checks on the vertex stream of the top level,
// bound to glyph_quad_layout_core. Depends on gql_pkg.
module gql_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_corner,
  input logic       out_last
);

  // output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("vertex valid right after reset");

  // a quad streams without gaps: next vertex follows with the next corner
  a_quad_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_corner == $past(out_corner) + 3'd1))
    else $error("quad vertex stream broken");

  // after the last vertex, anything shown next starts a new quad
  a_quad_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=>
      !out_valid || (out_corner == gql_pkg::CORNER_FIRST))
    else $error("new quad does not start at first corner");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_corner) && $stable(out_last))
    else $error("stalled vertex changed");

endmodule

bind glyph_quad_layout_core gql_checker u_gql_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_corner (out_ch.corner),
  .out_last   (out_ch.last)
);

// ----- test/quad_vertex_checker.sv -----
`timescale 1ns / 100ps
// quad_vertex_checker: watches the item, vertex and register channels of the
// glyph quad layout core, predicts every vertex and compares. Needs gql_pkg, gql_if.
module quad_vertex_checker (
  input  logic clk,
  input  logic rst_n,
  gql_in_if    in_ch,
  gql_out_if   out_ch,
  gql_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   vertices_owed
);

  // corners 1, 2, 4 take the right edge and u1; corners 2, 4, 5 the top and vt
  localparam logic [5:0] USES_RIGHT = 6'b010110;
  localparam logic [5:0] USES_TOP   = 6'b110100;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic [30:0] width;
    logic [30:0] height;
    logic [31:0] x_off;
    logic [31:0] y_off;
    logic [30:0] advance;
  } glyph_entry_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
    logic [2:0]  corner;
    logic        last;
  } vertex_t;

  glyph_entry_t glyph_store [256];
  logic [31:0]  pen_x;
  logic [31:0]  pen_y;
  logic         screen_space;
  logic [30:0]  line_height;
  vertex_t      owed_vertices [$];

  // six vertices of the current character, then the pen moves on
  function automatic void predict_quad(input logic [7:0] code);
    glyph_entry_t g;
    vertex_t      vtx;
    logic [31:0]  left, right, top, bottom, u1, vb;
    g     = glyph_store[code];
    left  = pen_x + g.x_off;
    right = left + {1'b0, g.width};
    if (screen_space) begin
      top    = pen_y + g.y_off;
      bottom = top + {1'b0, g.height};
    end else begin
      top    = pen_y - g.y_off;
      bottom = top - {1'b0, g.height};
    end
    u1 = g.u + {1'b0, g.width};
    vb = g.v - {1'b0, g.height};
    for (int k = 0; k < 6; k++) begin
      vtx.x      = USES_RIGHT[k] ? right : left;
      vtx.y      = USES_TOP[k] ? top : bottom;
      vtx.u      = USES_RIGHT[k] ? u1 : g.u;
      vtx.v      = USES_TOP[k] ? g.v : vb;
      vtx.corner = 3'(k);
      vtx.last   = (3'(k) == gql_pkg::CORNER_LAST);
      owed_vertices.insert(owed_vertices.size(), vtx);
    end
    pen_x = pen_x + {1'b0, g.advance};
  endfunction

  function automatic void apply_item();
    case (gql_pkg::act_t'(in_ch.action))
      gql_pkg::ACT_WRITE: begin
        glyph_store[in_ch.char_code] = '{u: in_ch.glyph_u, v: in_ch.glyph_v,
                                         width: in_ch.glyph_width,
                                         height: in_ch.glyph_height,
                                         x_off: in_ch.glyph_x_offset,
                                         y_off: in_ch.glyph_y_offset,
                                         advance: in_ch.glyph_advance};
      end
      gql_pkg::ACT_BEGIN: begin
        pen_x = '0;
        pen_y = '0;
      end
      gql_pkg::ACT_PLACE: begin
        if (in_ch.char_code == gql_pkg::NEWLINE_CODE) begin
          pen_x = '0;
          pen_y = screen_space ? pen_y + {1'b0, line_height}
                               : pen_y - {1'b0, line_height};
        end else begin
          predict_quad(in_ch.char_code);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void compare_vertex();
    vertex_t want;
    if (owed_vertices.size() == 0) begin
      $error("vertex transaction with none expected: corner %0d x %h y %h",
             out_ch.corner, out_ch.vertex_x, out_ch.vertex_y);
      mismatch_count++;
    end else begin
      want = owed_vertices.pop_front();
      check_field("vertex_x", want.x, out_ch.vertex_x);
      check_field("vertex_y", want.y, out_ch.vertex_y);
      check_field("tex_u", want.u, out_ch.tex_u);
      check_field("tex_v", want.v, out_ch.tex_v);
      check_field("corner", 32'(want.corner), 32'(out_ch.corner));
      check_field("last", 32'(want.last), 32'(out_ch.last));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pen_x        = '0;
      pen_y        = '0;
      screen_space = 1'b0;
      line_height  = '0;
      owed_vertices.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (gql_pkg::cfg_reg_t'(cfg_ch.addr))
          gql_pkg::CFG_SCREEN_SPACE: screen_space = cfg_ch.data[0];
          gql_pkg::CFG_LINE_HEIGHT:  line_height  = cfg_ch.data[30:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) apply_item();
      if (out_ch.valid && out_ch.ready) compare_vertex();
    end
    vertices_owed = owed_vertices.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// testbench: stimulus and verdict for glyph_quad_layout_core.
// Needs gql_pkg, gql_if, the core RTL and quad_vertex_checker.
module testbench;

  // extra cycles after the last vertex: covers the pipe plus items
  // that yield nothing (glyph writes, begins, newlines) still in flight
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 160;   // long receiver stall, fills the pipe
  localparam int PHASE_ITEMS     = 40;    // items in each of the five random phases
  localparam int IDLE_PCT        = 28;

  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [30:0] U_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    gql_pkg::act_t action;
    logic [7:0]    code;
    logic [31:0]   u;
    logic [31:0]   v;
    logic [30:0]   width;
    logic [30:0]   height;
    logic [31:0]   x_off;
    logic [31:0]   y_off;
    logic [30:0]   advance;
  } layout_item_t;

  logic clk;
  logic rst_n;
  bit   steady_flow;    // no idling on either side
  bit   hold_phase;     // asks the receiver for one long stall
  int   mismatch_count;
  int   vertices_owed;

  // codes with a loaded glyph; placing anything else is off limits.
  // Code 10 is never in here: placing it is always a newline.
  bit         glyph_loaded [256];
  logic [7:0] placeable [$];

  gql_in_if  in_ch();
  gql_out_if out_ch();
  gql_cfg_if cfg_ch();

  glyph_quad_layout_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  quad_vertex_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .vertices_owed  (vertices_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Q16.16 values: full-range noise, small signed, whole pixels, small positive
  function automatic logic [31:0] coord_value();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
      2:       return 32'($urandom_range(64)) << 16;
      default: return $urandom() & 32'h001F_FFFF;
    endcase
  endfunction

  function automatic layout_item_t glyph_item(input logic [7:0] code,
                                              input logic [31:0] u, v,
                                              input logic [30:0] width, height,
                                              input logic [31:0] x_off, y_off,
                                              input logic [30:0] advance);
    return '{action: gql_pkg::ACT_WRITE, code: code, u: u, v: v, width: width,
             height: height, x_off: x_off, y_off: y_off, advance: advance};
  endfunction

  // non-write items carry junk in the glyph fields; the block must ignore it
  function automatic layout_item_t ctrl_item(input gql_pkg::act_t action,
                                             input logic [7:0] code);
    return '{action: action, code: code, u: $urandom(), v: $urandom(),
             width: 31'($urandom()), height: 31'($urandom()), x_off: $urandom(),
             y_off: $urandom(), advance: 31'($urandom())};
  endfunction

  // mostly placements of loaded glyphs, with glyph writes, newlines, begins
  // and the odd reserved opcode mixed in
  function automatic layout_item_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 18)
      return glyph_item(8'($urandom_range(255)), coord_value(), coord_value(),
                        31'(coord_value()), 31'(coord_value()), coord_value(),
                        coord_value(), 31'(coord_value()));
    if (pick < 30) return ctrl_item(gql_pkg::ACT_PLACE, gql_pkg::NEWLINE_CODE);
    if (pick < 35) return ctrl_item(gql_pkg::ACT_BEGIN, 8'($urandom_range(255)));
    if (pick < 38) return ctrl_item(gql_pkg::ACT_RSVD, 8'($urandom_range(255)));
    return ctrl_item(gql_pkg::ACT_PLACE,
                     placeable[$urandom_range(placeable.size() - 1)]);
  endfunction

  // one input transaction; entered and left at a falling edge, valid still
  // high on exit so back-to-back items keep it up
  task automatic send_item(input layout_item_t item);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= item.action;
    in_ch.char_code      <= item.code;
    in_ch.glyph_u        <= item.u;
    in_ch.glyph_v        <= item.v;
    in_ch.glyph_width    <= item.width;
    in_ch.glyph_height   <= item.height;
    in_ch.glyph_x_offset <= item.x_off;
    in_ch.glyph_y_offset <= item.y_off;
    in_ch.glyph_advance  <= item.advance;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (item.action == gql_pkg::ACT_WRITE && item.code != gql_pkg::NEWLINE_CODE &&
        !glyph_loaded[item.code]) begin
      glyph_loaded[item.code] = 1'b1;
      placeable.insert(placeable.size(), item.code);
    end
  endtask

  task automatic place_char(input logic [7:0] code);
    send_item(ctrl_item(gql_pkg::ACT_PLACE, code));
  endtask

  // wait for every predicted vertex, then let silent items finish
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (vertices_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input gql_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // registers change only with the block idle; unused data bits get junk
  task automatic set_layout(input logic screen_space, input logic [30:0] line_height);
    drain_results();
    write_reg(gql_pkg::CFG_SCREEN_SPACE, {31'($urandom()), screen_space});
    write_reg(gql_pkg::CFG_LINE_HEIGHT, {1'($urandom()), line_height});
  endtask

  task automatic run_random_phase(input int count);
    layout_item_t item;
    int           sent;
    sent = 0;
    while (sent < count) begin
      item = random_item();
      send_item(item);
      if (item.action != gql_pkg::ACT_RSVD) sent++;
    end
  endtask

  // vertex receiver: random stalls, a no-stall stretch, and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (steady_flow) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    // every input known from time zero
    rst_n                = 1'b0;
    steady_flow          = 1'b0;
    hold_phase           = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = gql_pkg::ACT_WRITE;
    in_ch.char_code      = '0;
    in_ch.glyph_u        = '0;
    in_ch.glyph_v        = '0;
    in_ch.glyph_width    = '0;
    in_ch.glyph_height   = '0;
    in_ch.glyph_x_offset = '0;
    in_ch.glyph_y_offset = '0;
    in_ch.glyph_advance  = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.addr          = gql_pkg::CFG_SCREEN_SPACE;
    cfg_ch.data          = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: upward layout with the tallest line step
    set_layout(1'b0, U_MAX);
    send_item(glyph_item(8'd0, '0, '0, '0, '0, '0, '0, '0));
    send_item(glyph_item(8'd255, S_MIN, S_MAX, U_MAX, '0, S_MIN, S_MAX, U_MAX));
    send_item(glyph_item(8'd65, S_MAX, S_MIN, '0, U_MAX, S_MAX, S_MIN, '0));
    // entry 10 loads, but placing code 10 must still act as a newline
    send_item(glyph_item(gql_pkg::NEWLINE_CODE, $urandom(), $urandom(),
                         31'($urandom()), 31'($urandom()), $urandom(), $urandom(),
                         31'($urandom())));
    place_char(8'd0);
    place_char(8'd255);
    place_char(8'd255);              // pen_x wraps past the top of the range
    place_char(8'd65);
    place_char(gql_pkg::NEWLINE_CODE);
    place_char(8'd65);
    send_item(ctrl_item(gql_pkg::ACT_RSVD, 8'd65));
    place_char(8'd255);
    send_item(ctrl_item(gql_pkg::ACT_BEGIN, 8'd255));
    place_char(8'd0);
    place_char(gql_pkg::NEWLINE_CODE);
    place_char(gql_pkg::NEWLINE_CODE);

    // directed: screen space, zero line height
    set_layout(1'b1, '0);
    place_char(8'd255);
    place_char(gql_pkg::NEWLINE_CODE);
    place_char(8'd65);
    send_item(ctrl_item(gql_pkg::ACT_BEGIN, 8'd0));
    place_char(8'd255);
    place_char(gql_pkg::NEWLINE_CODE);

    // random phases across register settings
    set_layout(1'b0, 31'($urandom()));
    run_random_phase(PHASE_ITEMS);

    set_layout(1'b1, 31'($urandom()));
    steady_flow = 1'b1;
    run_random_phase(PHASE_ITEMS);
    steady_flow = 1'b0;

    // receiver stalls long while items keep coming: backpressure reaches in_ch
    set_layout(1'b1, U_MAX);
    hold_phase = 1'b1;
    run_random_phase(PHASE_ITEMS);
    hold_phase = 1'b0;

    set_layout(1'b0, '0);
    run_random_phase(PHASE_ITEMS);

    set_layout(1'($urandom()), 31'($urandom()));
    run_random_phase(PHASE_ITEMS);

    drain_results();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
